// File: rtl/ufib_pkg.sv
`default_nettype none

package ufib_pkg;

    // Fixed field widths of the panel and the serial link.
    localparam int unsigned PIN_BITS  = 12;
    localparam int unsigned LED_BITS  = 8;
    localparam int unsigned SEG_BITS  = 11;
    localparam int unsigned REPLY_LEN = 10;
    localparam int unsigned IDX_W     = $clog2(REPLY_LEN);

    // Byte that opens every command frame and every reply.
    localparam logic [7:0] FRAME_HEADER = 8'hAA;

    // Payload of one received byte together with the sampled panel inputs.
    typedef struct packed {
        logic [7:0]          rx_byte;
        logic [3:0]          toggle_pins;
        logic [3:0]          button_pins;
        logic [PIN_BITS-1:0] pot_a;
        logic [PIN_BITS-1:0] pot_b;
        logic [PIN_BITS-1:0] pot_c;
        logic [PIN_BITS-1:0] pot_d;
    } in_item_t;

    // Payload of one reply byte.
    typedef struct packed {
        logic [7:0]          tx_byte;
        logic                reply_last;
        logic [LED_BITS-1:0] led_drive;
        logic [SEG_BITS-1:0] segment_drive;
    } out_item_t;

    // Status of the reply job queue as seen by its neighbors.
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

`default_nettype wire

// File: rtl/ufib_if.sv
`default_nettype none

// Channel carrying received bytes into the bridge.
interface ufib_in_if;
    logic               valid;
    logic               ready;
    ufib_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Channel carrying reply bytes out of the bridge.
interface ufib_out_if;
    logic                valid;
    logic                ready;
    ufib_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/ufib_front.sv
`default_nettype none

module ufib_front #(
    parameter int unsigned KEPT  = 12,
    parameter int unsigned JOB_W = 4 * KEPT + 27
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    ufib_in_if.sink                   rx,
    input  wire ufib_pkg::q_status_t  q_status,
    output logic                      push,
    output logic [JOB_W-1:0]          push_job
);

    logic                              collecting_reg, collecting_next;
    logic [1:0]                        data_count_reg, data_count_next;
    logic [7:0]                        captured_reg [2];
    logic [ufib_pkg::LED_BITS-1:0]     led_reg, led_next;
    logic [ufib_pkg::SEG_BITS-1:0]     seg_reg, seg_next;
    logic                              accept;
    logic                              frame_end;
    logic [7:0]                        switch_byte;

    // A frame-completing transaction needs room in the queue; all others pass freely.
    assign frame_end = collecting_reg && data_count_reg[1];
    assign rx.ready  = !(frame_end && q_status.full);
    assign accept    = rx.valid && rx.ready;
    assign push      = accept && frame_end;

    // Toggles raw in the low nibble, active-low buttons inverted in the high nibble.
    assign switch_byte = {~rx.data.button_pins, rx.data.toggle_pins};

    // Frame parser: hunt for the header, then gather three data bytes.
    always_comb
    begin
        collecting_next = collecting_reg;
        data_count_next = data_count_reg;
        led_next        = led_reg;
        seg_next        = seg_reg;
        if (accept)
        begin
            if (!collecting_reg)
            begin
                if (rx.data.rx_byte == ufib_pkg::FRAME_HEADER)
                begin
                    collecting_next = 1'b1;
                    data_count_next = 2'd0;
                end
            end
            else if (!data_count_reg[1])
            begin
                data_count_next = data_count_reg + 2'd1;
            end
            else
            begin
                led_next        = captured_reg[0];
                seg_next        = {rx.data.rx_byte[2:0], captured_reg[1]};
                collecting_next = 1'b0;
                data_count_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            data_count_reg <= 2'd0;
            led_reg        <= '0;
            seg_reg        <= '0;
        end
        else
        begin
            collecting_reg <= collecting_next;
            data_count_reg <= data_count_next;
            led_reg        <= led_next;
            seg_reg        <= seg_next;
        end
    end

    // The first two data bytes are held until the third one arrives.
    always_ff @(posedge clk)
    begin
        if (accept && collecting_reg && !data_count_reg[1])
        begin
            captured_reg[data_count_reg[0]] <= rx.data.rx_byte;
        end
    end

    // Reply job: latched outputs, switch byte and the masked pot samples.
    assign push_job = {seg_next, led_next, switch_byte,
                       rx.data.pot_d[KEPT-1:0], rx.data.pot_c[KEPT-1:0],
                       rx.data.pot_b[KEPT-1:0], rx.data.pot_a[KEPT-1:0]};

    push_only_at_frame_end : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (collecting_reg && data_count_reg == 2'd2))
        else $error("reply job pushed outside the third data byte");

    frame_end_returns_to_hunt : assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (!collecting_reg && data_count_reg == 2'd0))
        else $error("parser did not return to hunting after a frame");

    count_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        data_count_reg != 2'd3)
        else $error("data count out of range");

endmodule

`default_nettype wire

// File: rtl/ufib_queue.sv
`default_nettype none

module ufib_queue #(
    parameter int unsigned JOB_W = 75
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic [JOB_W-1:0]     push_job,
    input  wire logic                 pop,
    output logic [JOB_W-1:0]          head_job,
    output ufib_pkg::q_status_t       status
);

    logic [JOB_W-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg,  count_next;

    // Pointer and occupancy update for a two-entry queue.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job         = entry_reg[rd_ptr_reg];
    assign status.full      = count_reg[1];
    assign status.not_empty = count_reg != 2'd0;

    no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!count_reg[1] || pop))
        else $error("reply job queue overflow");

    no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != 2'd0))
        else $error("reply job queue underflow");

    count_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("reply job queue count out of range");

endmodule

`default_nettype wire

// File: rtl/ufib_back.sv
`default_nettype none

module ufib_back #(
    parameter int unsigned KEPT  = 12,
    parameter int unsigned JOB_W = 4 * KEPT + 27
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ufib_pkg::q_status_t  q_status,
    input  wire logic [JOB_W-1:0]     head_job,
    output logic                      pop,
    ufib_out_if.source                tx
);

    localparam logic [ufib_pkg::IDX_W-1:0] LAST_IDX =
        ufib_pkg::IDX_W'(ufib_pkg::REPLY_LEN - 1);
    localparam logic [ufib_pkg::IDX_W-1:0] FIRST_IDX = '0;

    logic [ufib_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [ufib_pkg::IDX_W-1:0]    idx_m1;
    logic                          out_valid_reg, out_valid_next;
    ufib_pkg::out_item_t           out_reg, out_next;
    logic                          load;
    logic [1:0]                    pot_sel;
    logic [KEPT-1:0]               pot_val;
    logic [15:0]                   pot_word;
    logic [7:0]                    byte_val;
    logic [7:0]                    switch_byte;
    logic [ufib_pkg::LED_BITS-1:0] led_val;
    logic [ufib_pkg::SEG_BITS-1:0] seg_val;

    // Fields of the job at the head of the queue.
    assign switch_byte = head_job[4*KEPT +: 8];
    assign led_val     = head_job[4*KEPT + 8 +: ufib_pkg::LED_BITS];
    assign seg_val     = head_job[4*KEPT + 16 +: ufib_pkg::SEG_BITS];

    // Pot bytes follow the header in low/high pairs.
    assign idx_m1   = idx_reg - 1'b1;
    assign pot_sel  = idx_m1[2:1];
    assign pot_val  = head_job[pot_sel*KEPT +: KEPT];
    assign pot_word = 16'(pot_val);

    always_comb
    begin
        if (idx_reg == FIRST_IDX)
        begin
            byte_val = ufib_pkg::FRAME_HEADER;
        end
        else if (idx_reg == LAST_IDX)
        begin
            byte_val = switch_byte;
        end
        else if (idx_m1[0])
        begin
            byte_val = pot_word[15:8];
        end
        else
        begin
            byte_val = pot_word[7:0];
        end
    end

    // The output register refills, while a job is queued, whenever it is empty or being drained.
    assign load = q_status.not_empty && (!out_valid_reg || tx.ready);
    assign pop  = load && (idx_reg == LAST_IDX);

    always_comb
    begin
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !tx.ready;
        if (load)
        begin
            idx_next                = (idx_reg == LAST_IDX) ? FIRST_IDX : idx_reg + 1'b1;
            out_valid_next          = 1'b1;
            out_next.tx_byte        = byte_val;
            out_next.reply_last     = idx_reg == LAST_IDX;
            out_next.led_drive      = led_val;
            out_next.segment_drive  = seg_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= FIRST_IDX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign tx.valid = out_valid_reg;
    assign tx.data  = out_reg;

    idx_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_IDX)
        else $error("reply byte index out of range");

    reply_opens_with_header : assert property (@(posedge clk) disable iff (!rst_n)
        (load && idx_reg == FIRST_IDX) |=> (tx.data.tx_byte == ufib_pkg::FRAME_HEADER
                                             && !tx.data.reply_last))
        else $error("reply does not open with the header");

    last_byte_restarts : assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == FIRST_IDX && tx.data.reply_last))
        else $error("reply index did not restart after the last byte");

endmodule

`default_nettype wire

// File: rtl/uart_frame_io_bridge_core.sv
`default_nettype none

// Serial frame bridge for a small I/O panel. Received bytes are dropped until
// the header 0xAA; the next three bytes form a command that sets the LED byte
// and the 11 segment bits, and each command produces a 10-byte reply (header,
// four pot samples as little-endian 16-bit words masked to min(POT_BITS,
// PIN_BITS) bits, and the switch byte) on the output channel, one byte per
// cycle while the output channel is ready. The input side accepts one
// transaction per cycle; it stalls only on a command-completing byte while
// the two-entry reply job queue is full. Reply output is paced by the single
// byte serializer, so back-to-back commands are bound by ten reply bytes per
// four input bytes. With no earlier reply in flight, the first reply byte is
// stored in the job queue and then the output register before it is valid.
module uart_frame_io_bridge_core #(
    parameter int unsigned POT_BITS = 12
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ufib_in_if.sink     rx_chan,
    ufib_out_if.source  tx_chan
);

    localparam int unsigned KEPT  = (POT_BITS < ufib_pkg::PIN_BITS) ?
                                    POT_BITS : ufib_pkg::PIN_BITS;
    localparam int unsigned JOB_W = 4 * KEPT + 8 + ufib_pkg::LED_BITS
                                    + ufib_pkg::SEG_BITS;

    ufib_pkg::q_status_t q_status;
    logic                push;
    logic [JOB_W-1:0]    push_job;
    logic                pop;
    logic [JOB_W-1:0]    head_job;

    // Parser and reply job builder.
    ufib_front #(
        .KEPT  (KEPT),
        .JOB_W (JOB_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx_chan),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    // Queue of pending replies between parser and serializer.
    ufib_queue #(
        .JOB_W (JOB_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // Reply byte serializer with output register.
    ufib_back #(
        .KEPT  (KEPT),
        .JOB_W (JOB_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head_job (head_job),
        .pop      (pop),
        .tx       (tx_chan)
    );

endmodule

`default_nettype wire
